>>> rtl/lzs_pkg.sv
`timescale 1ns / 1ps
// Package for the longest zero-sum span unit: default sizes, field widths,
// hash constants and the table control struct. No dependencies.
package lzs_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int TABLE_SLOTS_DEF = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  // Result field widths are fixed by the output word layout.
  localparam int SPAN_W      = 10;
  localparam int LEN_W       = 11;
  localparam int OUT_FIELDS_W = 1 + SPAN_W + SPAN_W + LEN_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Multiplicative hash: h = key * HASH_MULT, then h ^= h >> HASH_SHIFT.
  localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
  localparam int          HASH_SHIFT = 29;
  localparam int          CHUNK_W    = 16;

  localparam int EPOCH_W = 8;

  typedef struct packed {
    logic rd_en;     // read all fields of the probed slot
    logic wr_en;     // write the slot epoch
    logic wr_entry;  // also write key and first index
  } lzs_tbl_ctl_t;

endpackage

>>> rtl/lzs_hash.sv
`timescale 1ns / 1ps
// Iterative hash unit: multiply-accumulate over 16-bit key chunks, one a cycle.
// Depends on lzs_pkg.
module lzs_hash #(
  parameter int PSUM_W    = 27,
  parameter int SLOT_BITS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic signed [PSUM_W-1:0]    key_i,
  output logic                        done_o,
  output logic [SLOT_BITS-1:0]        slot_o
);
  import lzs_pkg::*;

  localparam int HASH_BITS = HASH_SHIFT + SLOT_BITS;
  localparam int CHUNKS    = (HASH_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W     = CHUNKS * CHUNK_W;
  localparam int CNT_W     = $clog2(CHUNKS);
  localparam logic [HASH_BITS-1:0] MULT = HASH_MULT[HASH_BITS-1:0];

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [HASH_BITS-1:0]          acc_r;
  logic [PAD_W-1:0]              key_sh_r;
  logic [CHUNK_W+HASH_BITS-1:0]  prod;
  logic [HASH_BITS-1:0]          acc_nxt;

  // Horner form over chunks, most significant first: only the low HASH_BITS
  // of the product are ever needed.
  always_comb begin
    prod    = key_sh_r[PAD_W-1 -: CHUNK_W] * MULT;
    acc_nxt = {acc_r[HASH_BITS-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + prod[HASH_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
      acc_r    <= '0;
      key_sh_r <= '0;
    end else begin
      done_r <= !start_i && busy_r && (cnt_r == CNT_W'(CHUNKS - 1));
      if (start_i) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        acc_r    <= '0;
        key_sh_r <= PAD_W'(key_i);
      end else if (busy_r) begin
        acc_r    <= acc_nxt;
        key_sh_r <= {key_sh_r[PAD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
        cnt_r    <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CHUNKS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_r;
  assign slot_o = acc_r[SLOT_BITS-1:0] ^ acc_r[HASH_SHIFT +: SLOT_BITS];

endmodule

>>> rtl/lzs_table.sv
`timescale 1ns / 1ps
// Hash table store: key, first index and epoch per slot, one write and one
// registered read per cycle. Depends on lzs_pkg.
module lzs_table #(
  parameter int SLOT_BITS = 11,
  parameter int PSUM_W    = 27,
  parameter int IDX_W     = 10
) (
  input  logic                        clk,
  input  lzs_pkg::lzs_tbl_ctl_t       ctl_i,
  input  logic [SLOT_BITS-1:0]        rd_addr_i,
  input  logic [SLOT_BITS-1:0]        wr_addr_i,
  input  logic [PSUM_W-1:0]           wr_key_i,
  input  logic [IDX_W-1:0]            wr_idx_i,
  input  logic [lzs_pkg::EPOCH_W-1:0] wr_epoch_i,
  output logic [PSUM_W-1:0]           rd_key_o,
  output logic [IDX_W-1:0]            rd_idx_o,
  output logic [lzs_pkg::EPOCH_W-1:0] rd_epoch_o
);
  import lzs_pkg::*;

  localparam int SLOTS = 1 << SLOT_BITS;

  logic [PSUM_W-1:0]  key_mem   [SLOTS];
  logic [IDX_W-1:0]   idx_mem   [SLOTS];
  logic [EPOCH_W-1:0] epoch_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) begin
      epoch_mem[wr_addr_i] <= wr_epoch_i;
    end
    if (ctl_i.wr_entry) begin
      key_mem[wr_addr_i] <= wr_key_i;
      idx_mem[wr_addr_i] <= wr_idx_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.rd_en) begin
      rd_key_o   <= key_mem[rd_addr_i];
      rd_idx_o   <= idx_mem[rd_addr_i];
      rd_epoch_o <= epoch_mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/longest_zero_sum_subarray_span_unit.sv
`timescale 1ns / 1ps
// Longest zero-sum span unit. An accepted sample word goes through check, hash,
// read and compare for each slot probed (one when the home slot decides), update;
// with a zero prefix sum it goes from check to update, beyond MAX_ITEMS straight to
// update. A final word adds a report step, then the result word waits in an output
// register. After reset, and after every 255th array, a clearing pass empties the
// table; in_tready stays low during it. Reset is synchronous, active low.
module longest_zero_sum_subarray_span_unit #(
  parameter int MAX_ITEMS   = lzs_pkg::MAX_ITEMS_DEF,
  parameter int TABLE_SLOTS = lzs_pkg::TABLE_SLOTS_DEF,
  parameter int SAMPLE_BITS = lzs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // sample
  input  logic                                  in_tlast,   // final_sample
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // found, span_start, span_end, span_length, too_long
  output logic [lzs_pkg::OUT_TDATA_W-1:0]       out_tdata
);
  import lzs_pkg::*;

  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int PSUM_W    = SAMPLE_BITS + IDX_W + 1;
  localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
  localparam int PROBE_W   = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_HASH, S_READ, S_CMP, S_UPDATE, S_REPORT, S_CLEAR
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [PSUM_W-1:0]  psum_r, psum_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [IDX_W-1:0]          best_start_r, best_start_nxt;
  logic [IDX_W-1:0]          best_end_r, best_end_nxt;
  logic [CNT_W-1:0]          best_len_r, best_len_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [EPOCH_W-1:0]        epoch_r, epoch_nxt;
  logic                      last_r, last_nxt;
  logic                      skip_r, skip_nxt;
  logic                      hit_r, hit_nxt;
  logic [IDX_W-1:0]          cand_start_r, cand_start_nxt;
  logic [CNT_W-1:0]          cand_len_r, cand_len_nxt;
  logic [SLOT_BITS-1:0]      probe_addr_r, probe_addr_nxt;
  logic [PROBE_W-1:0]        probe_cnt_r, probe_cnt_nxt;
  logic [SLOT_BITS-1:0]      clr_addr_r, clr_addr_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]    out_tdata_r, out_tdata_nxt;

  logic signed [SAMPLE_BITS-1:0] sample_s;
  logic                      hash_start;
  logic                      hash_done;
  logic [SLOT_BITS-1:0]      hash_slot;
  lzs_tbl_ctl_t              tbl_ctl;
  logic [SLOT_BITS-1:0]      tbl_wr_addr;
  logic [EPOCH_W-1:0]        tbl_wr_epoch;
  logic [PSUM_W-1:0]         rd_key;
  logic [IDX_W-1:0]          rd_idx;
  logic [EPOCH_W-1:0]        rd_epoch;
  logic                      slot_empty;
  logic [PROBE_W-1:0]        probe_cnt_inc;

  assign sample_s      = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready     = (state_r == S_IDLE);
  assign slot_empty    = (rd_epoch != epoch_r);
  assign probe_cnt_inc = probe_cnt_r + PROBE_W'(1);
  assign hash_start    = (state_r == S_CHECK) && (psum_r != '0);

  always_comb begin
    tbl_ctl          = '0;
    tbl_ctl.rd_en    = (state_r == S_READ);
    tbl_ctl.wr_en    = (state_r == S_CLEAR) || ((state_r == S_CMP) && slot_empty);
    tbl_ctl.wr_entry = (state_r == S_CMP) && slot_empty;
    tbl_wr_addr      = (state_r == S_CLEAR) ? clr_addr_r : probe_addr_r;
    tbl_wr_epoch     = (state_r == S_CLEAR) ? '0 : epoch_r;
  end

  lzs_hash #(
    .PSUM_W    (PSUM_W),
    .SLOT_BITS (SLOT_BITS)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (hash_start),
    .key_i   (psum_r),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  lzs_table #(
    .SLOT_BITS (SLOT_BITS),
    .PSUM_W    (PSUM_W),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk        (clk),
    .ctl_i      (tbl_ctl),
    .rd_addr_i  (probe_addr_r),
    .wr_addr_i  (tbl_wr_addr),
    .wr_key_i   (psum_r),
    .wr_idx_i   (idx_r[IDX_W-1:0]),
    .wr_epoch_i (tbl_wr_epoch),
    .rd_key_o   (rd_key),
    .rd_idx_o   (rd_idx),
    .rd_epoch_o (rd_epoch)
  );

  always_comb begin
    state_nxt      = state_r;
    psum_nxt       = psum_r;
    idx_nxt        = idx_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    best_len_nxt   = best_len_r;
    ovf_nxt        = ovf_r;
    epoch_nxt      = epoch_r;
    last_nxt       = last_r;
    skip_nxt       = skip_r;
    hit_nxt        = hit_r;
    cand_start_nxt = cand_start_r;
    cand_len_nxt   = cand_len_r;
    probe_addr_nxt = probe_addr_r;
    probe_cnt_nxt  = probe_cnt_r;
    clr_addr_nxt   = clr_addr_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt = in_tlast;
          hit_nxt  = 1'b0;
          // Words past the array limit leave the sum and the table alone.
          if (idx_r >= CNT_W'(MAX_ITEMS)) begin
            skip_nxt  = 1'b1;
            ovf_nxt   = 1'b1;
            state_nxt = S_UPDATE;
          end else begin
            skip_nxt  = 1'b0;
            psum_nxt  = psum_r + PSUM_W'(sample_s);
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        // A zero sum matches the empty prefix, so it needs no table access.
        if (psum_r == '0) begin
          hit_nxt        = 1'b1;
          cand_start_nxt = '0;
          cand_len_nxt   = idx_r + CNT_W'(1);
          state_nxt      = S_UPDATE;
        end else begin
          state_nxt = S_HASH;
        end
      end

      S_HASH: begin
        if (hash_done) begin
          probe_addr_nxt = hash_slot;
          probe_cnt_nxt  = '0;
          state_nxt      = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (slot_empty) begin
          state_nxt = S_UPDATE;
        end else if (rd_key == psum_r) begin
          hit_nxt        = 1'b1;
          cand_start_nxt = rd_idx + IDX_W'(1);
          cand_len_nxt   = idx_r - CNT_W'(rd_idx);
          state_nxt      = S_UPDATE;
        end else begin
          probe_addr_nxt = probe_addr_r + SLOT_BITS'(1);
          probe_cnt_nxt  = probe_cnt_inc;
          // Having walked every slot, the sum counts as unseen and is dropped.
          if (probe_cnt_inc == PROBE_W'(TABLE_SLOTS)) begin
            state_nxt = S_UPDATE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_UPDATE: begin
        if (!skip_r) begin
          idx_nxt = idx_r + CNT_W'(1);
          if (hit_r && (cand_len_r > best_len_r)) begin
            best_start_nxt = cand_start_r;
            best_end_nxt   = idx_r[IDX_W-1:0];
            best_len_nxt   = cand_len_r;
          end
        end
        state_nxt = last_r ? S_REPORT : S_IDLE;
      end

      S_REPORT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({ovf_r,
                                         LEN_W'(best_len_r),
                                         SPAN_W'(best_end_r),
                                         SPAN_W'(best_start_r),
                                         (best_len_r != '0)});
          psum_nxt       = '0;
          idx_nxt        = '0;
          best_start_nxt = '0;
          best_end_nxt   = '0;
          best_len_nxt   = '0;
          ovf_nxt        = 1'b0;
          // The epoch tag never takes the empty value; on wrap the table is swept.
          if (epoch_r == '1) begin
            epoch_nxt    = EPOCH_W'(1);
            clr_addr_nxt = '0;
            state_nxt    = S_CLEAR;
          end else begin
            epoch_nxt = epoch_r + EPOCH_W'(1);
            state_nxt = S_IDLE;
          end
        end
      end

      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + SLOT_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      psum_r       <= '0;
      idx_r        <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
      best_len_r   <= '0;
      ovf_r        <= 1'b0;
      epoch_r      <= EPOCH_W'(1);
      last_r       <= 1'b0;
      skip_r       <= 1'b0;
      hit_r        <= 1'b0;
      cand_start_r <= '0;
      cand_len_r   <= '0;
      probe_addr_r <= '0;
      probe_cnt_r  <= '0;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      psum_r       <= psum_nxt;
      idx_r        <= idx_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      best_len_r   <= best_len_nxt;
      ovf_r        <= ovf_nxt;
      epoch_r      <= epoch_nxt;
      last_r       <= last_nxt;
      skip_r       <= skip_nxt;
      hit_r        <= hit_nxt;
      cand_start_r <= cand_start_nxt;
      cand_len_r   <= cand_len_nxt;
      probe_addr_r <= probe_addr_nxt;
      probe_cnt_r  <= probe_cnt_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_tdata_r  <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The best span always lies within the elements taken so far.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    best_len_r <= idx_r)
    else $error("best span longer than the array so far");

  a_span_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (best_len_r != '0) |->
      (CNT_W'(best_end_r) - CNT_W'(best_start_r) + CNT_W'(1) == best_len_r))
    else $error("best span bounds disagree with its length");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch tag took the empty value");

  a_hash_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == S_HASH))
    else $error("hash finished outside the hash step");

  a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_REPORT))
    else $error("result word raised outside the report step");

endmodule
